/* src/wmpv_pkg.sv */
package wmpv_pkg;

	// Default widths of the sample, the running sum and the event counts
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int SUM_WIDTH_DEF    = 48;
	localparam int COUNT_WIDTH_DEF  = 24;

	// Control carried alongside a window that yields a result
	typedef struct packed {
		logic valid;
		logic peak;
		logic valley;
		logic last;
	} wmpv_ctl_t;

endpackage

/* src/wmpv_accum.sv */
module wmpv_accum #(
	parameter int SAMPLE_WIDTH = wmpv_pkg::SAMPLE_WIDTH_DEF,
	parameter int SUM_WIDTH    = wmpv_pkg::SUM_WIDTH_DEF,
	parameter int COUNT_WIDTH  = wmpv_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wmpv_pkg::wmpv_ctl_t            ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] mean,
	input  logic signed [SAMPLE_WIDTH-1:0] centre,
	output logic                           advance,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic signed [SAMPLE_WIDTH:0]   filtered_value,
	output logic                           is_peak,
	output logic                           is_valley,
	output logic signed [SUM_WIDTH-1:0]    running_sum,
	output logic [COUNT_WIDTH-1:0]         peak_count,
	output logic [COUNT_WIDTH-1:0]         valley_count,
	output logic                           final_result
);

	localparam int EXT_W = ((SUM_WIDTH > SAMPLE_WIDTH + 1) ? SUM_WIDTH : SAMPLE_WIDTH + 1) + 1;

	logic signed [SUM_WIDTH-1:0]    sum_q;
	logic [COUNT_WIDTH-1:0]         pcnt_q;
	logic [COUNT_WIDTH-1:0]         vcnt_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH:0]   value_q;
	logic                           peak_q;
	logic                           valley_q;
	logic signed [SUM_WIDTH-1:0]    osum_q;
	logic [COUNT_WIDTH-1:0]         opcnt_q;
	logic [COUNT_WIDTH-1:0]         ovcnt_q;
	logic                           last_q;

	logic signed [SAMPLE_WIDTH:0]   value;
	logic signed [EXT_W-1:0]        sum_wide;
	logic                           sum_fits;
	logic signed [SUM_WIDTH-1:0]    sum_next;
	logic [COUNT_WIDTH-1:0]         pcnt_next;
	logic [COUNT_WIDTH-1:0]         vcnt_next;
	logic                           take;

	// Advance whenever the result register is empty or being drained
	assign advance = !out_valid_q || result_ready;
	assign take    = ctl.valid && advance;

	// Add the centre sample on a peak
	assign value = (SAMPLE_WIDTH + 1)'(mean)
		+ (ctl.peak ? (SAMPLE_WIDTH + 1)'(centre) : '0);

	// Saturate the running sum at the signed limits
	always_comb begin
		sum_wide = EXT_W'(sum_q) + EXT_W'(value);
		sum_fits = (&sum_wide[EXT_W-1:SUM_WIDTH-1]) || !(|sum_wide[EXT_W-1:SUM_WIDTH-1]);
		if (sum_fits) begin
			sum_next = sum_wide[SUM_WIDTH-1:0];
		end else if (sum_wide[EXT_W-1]) begin
			sum_next = {1'b1, {(SUM_WIDTH-1){1'b0}}};
		end else begin
			sum_next = {1'b0, {(SUM_WIDTH-1){1'b1}}};
		end
	end

	// Count events, holding at all ones
	assign pcnt_next = (ctl.peak && !(&pcnt_q)) ? pcnt_q + 1'b1 : pcnt_q;
	assign vcnt_next = (ctl.valley && !(&vcnt_q)) ? vcnt_q + 1'b1 : vcnt_q;

	// Hold the per-vector totals, drop them after the final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			pcnt_q <= '0;
			vcnt_q <= '0;
		end else if (take) begin
			if (ctl.last) begin
				sum_q  <= '0;
				pcnt_q <= '0;
				vcnt_q <= '0;
			end else begin
				sum_q  <= sum_next;
				pcnt_q <= pcnt_next;
				vcnt_q <= vcnt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= ctl.valid;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (take) begin
			value_q  <= value;
			peak_q   <= ctl.peak;
			valley_q <= ctl.valley;
			osum_q   <= sum_next;
			opcnt_q  <= pcnt_next;
			ovcnt_q  <= vcnt_next;
			last_q   <= ctl.last;
		end
	end

	assign result_valid   = out_valid_q;
	assign filtered_value = value_q;
	assign is_peak        = peak_q;
	assign is_valley      = valley_q;
	assign running_sum    = osum_q;
	assign peak_count     = opcnt_q;
	assign valley_count   = ovcnt_q;
	assign final_result   = last_q;

endmodule

/* src/window_mean_peak_valley.sv */
// Three-point moving mean with peak and valley marking over a stream of
// sample vectors.
// Input channel: one signed Q8.8 sample per word, end_of_vector on the last
// sample of a vector. Output channel: one word per centre sample, from the
// third sample of a vector on; the first and last samples get none, and a
// vector of one or two samples gives nothing.
// Throughput: one sample per cycle, sustained, with result_ready held high.
// A result passes the window stage, with the divide-by-three multiply, and
// then the accumulate stage feeding the result register before it shows
// on result_valid.
// When the receiver stalls the result register holds, the window stage
// holds one more word, and sample_ready drops once both are full; a
// sample that yields no result still waits for the window stage to move.
// Reset clears the window, the running sum and both counts; a word marked
// final_result clears them again for the next vector.
module window_mean_peak_valley #(
	parameter int SAMPLE_WIDTH = wmpv_pkg::SAMPLE_WIDTH_DEF,
	parameter int SUM_WIDTH    = wmpv_pkg::SUM_WIDTH_DEF,
	parameter int COUNT_WIDTH  = wmpv_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           end_of_vector,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic signed [SAMPLE_WIDTH:0]   filtered_value,
	output logic                           is_peak,
	output logic                           is_valley,
	output logic signed [SUM_WIDTH-1:0]    running_sum,
	output logic [COUNT_WIDTH-1:0]         peak_count,
	output logic [COUNT_WIDTH-1:0]         valley_count,
	output logic                           final_result
);

	// Floor division by three through a reciprocal on the biased sum
	localparam int DIV_W  = SAMPLE_WIDTH + 2;
	localparam int DIV_SH = DIV_W + 1;
	localparam longint unsigned DIV_M = ((64'd1 << DIV_SH) + 64'd2) / 64'd3;
	localparam logic [DIV_W-1:0] DIV_RECIP = DIV_W'(DIV_M);

	logic signed [SAMPLE_WIDTH-1:0] older_q;
	logic signed [SAMPLE_WIDTH-1:0] newer_q;
	logic [1:0]                     fill_q;

	wmpv_pkg::wmpv_ctl_t            ctl_s1;
	logic signed [SAMPLE_WIDTH-1:0] mean_s1;
	logic signed [SAMPLE_WIDTH-1:0] centre_s1;

	logic                           advance;
	logic                           s1_free;
	logic                           accept;
	logic                           full;
	logic [SAMPLE_WIDTH-1:0]        older_u;
	logic [SAMPLE_WIDTH-1:0]        newer_u;
	logic [SAMPLE_WIDTH-1:0]        sample_u;
	logic [DIV_W-1:0]               tri_sum;
	logic [2*DIV_W-1:0]             prod;
	logic [SAMPLE_WIDTH-1:0]        quot;
	logic signed [SAMPLE_WIDTH-1:0] mean;
	logic                           peak;
	logic                           valley;

	assign s1_free      = !ctl_s1.valid || advance;
	assign sample_ready = s1_free;
	assign accept       = sample_valid && s1_free;
	assign full         = (fill_q == 2'd2);

	// Bias each sample by half range so the sum is never negative
	assign older_u  = {~older_q[SAMPLE_WIDTH-1], older_q[SAMPLE_WIDTH-2:0]};
	assign newer_u  = {~newer_q[SAMPLE_WIDTH-1], newer_q[SAMPLE_WIDTH-2:0]};
	assign sample_u = {~sample[SAMPLE_WIDTH-1], sample[SAMPLE_WIDTH-2:0]};
	assign tri_sum  = DIV_W'(older_u) + DIV_W'(newer_u) + DIV_W'(sample_u) + DIV_W'(1);
	assign prod     = (2*DIV_W)'(tri_sum) * (2*DIV_W)'(DIV_RECIP);
	assign quot     = prod[DIV_SH +: SAMPLE_WIDTH];

	// Remove the bias again: the quotient is offset by half range
	assign mean   = {~quot[SAMPLE_WIDTH-1], quot[SAMPLE_WIDTH-2:0]};
	assign peak   = (newer_q > older_q) && (newer_q > sample);
	assign valley = (newer_q < older_q) && (newer_q < sample);

	// Shift the window, drop it at the end of a vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= '0;
			newer_q <= '0;
			fill_q  <= '0;
		end else if (accept) begin
			if (end_of_vector) begin
				older_q <= '0;
				newer_q <= '0;
				fill_q  <= '0;
			end else begin
				older_q <= newer_q;
				newer_q <= sample;
				if (!full) begin
					fill_q <= fill_q + 2'd1;
				end
			end
		end
	end

	// Window stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (s1_free) begin
			ctl_s1.valid  <= accept && full;
			ctl_s1.peak   <= peak;
			ctl_s1.valley <= valley;
			ctl_s1.last   <= end_of_vector;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			mean_s1   <= mean;
			centre_s1 <= newer_q;
		end
	end

	wmpv_accum #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.SUM_WIDTH   (SUM_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl_s1),
		.mean          (mean_s1),
		.centre        (centre_s1),
		.advance       (advance),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.filtered_value(filtered_value),
		.is_peak       (is_peak),
		.is_valley     (is_valley),
		.running_sum   (running_sum),
		.peak_count    (peak_count),
		.valley_count  (valley_count),
		.final_result  (final_result)
	);

endmodule

/* src/wmpv_checker.sv */
module wmpv_checker #(
	parameter int SAMPLE_WIDTH = wmpv_pkg::SAMPLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = wmpv_pkg::COUNT_WIDTH_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic signed [SAMPLE_WIDTH:0] filtered_value,
	input logic                         is_peak,
	input logic                         is_valley,
	input logic [COUNT_WIDTH-1:0]       peak_count,
	input logic [COUNT_WIDTH-1:0]       valley_count
);

	// A stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(filtered_value))
		else $error("result word changed while stalled");

	// A centre cannot be both a peak and a valley
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(is_peak && is_valley))
		else $error("peak and valley flagged together");

	// A flagged peak is counted
	a_pcnt: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_peak |-> peak_count != '0)
		else $error("peak flagged with zero peak count");

	// A flagged valley is counted
	a_vcnt: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_valley |-> valley_count != '0)
		else $error("valley flagged with zero valley count");

endmodule

bind window_mean_peak_valley wmpv_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH),
	.COUNT_WIDTH (COUNT_WIDTH)
) u_wmpv_checker (.*);

/* bench/tb_top.sv */
module tb_top;

	localparam int SW = wmpv_pkg::SAMPLE_WIDTH_DEF;
	localparam int SUMW = wmpv_pkg::SUM_WIDTH_DEF;
	localparam int CW = wmpv_pkg::COUNT_WIDTH_DEF;
	localparam int ITEM_TARGET = 1600;
	localparam int CALM_FROM = 1400;
	localparam int HOLD_OFF_AT = 150;
	localparam int HOLD_OFF_CYCLES = 64;
	localparam int DRAIN_CYCLES = 8;

	// One centre-sample result as it leaves the block
	typedef struct packed {
		logic signed [SW:0]     mean_val;
		logic                   peak;
		logic                   valley;
		logic signed [SUMW-1:0] total;
		logic [CW-1:0]          peaks;
		logic [CW-1:0]          valleys;
		logic                   closing;
	} centre_t;

	// Directed stimulus row; the typed result is used only where pinned
	typedef struct packed {
		logic signed [SW-1:0]   smp;
		logic                   eov;
		logic                   pinned;
		logic                   yields;
		logic signed [SW:0]     mean_val;
		logic                   peak;
		logic                   valley;
		logic signed [SUMW-1:0] total;
		logic [CW-1:0]          peaks;
		logic [CW-1:0]          valleys;
	} stim_row_t;

	typedef enum int {S_WIDE, S_NARROW, S_EDGES, S_WALK, S_FLAT} sample_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic signed [SW-1:0] sample = '0;
	logic end_of_vector = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [SW:0] filtered_value;
	logic is_peak;
	logic is_valley;
	logic signed [SUMW-1:0] running_sum;
	logic [CW-1:0] peak_count;
	logic [CW-1:0] valley_count;
	logic final_result;

	// Predictor state
	longint older_smp;
	longint newer_smp;
	int window_fill;
	longint sum_acc;
	logic [CW-1:0] peak_tally;
	logic [CW-1:0] valley_tally;

	centre_t pending_centres[$];
	int mismatches = 0;
	int words_out = 0;
	int words_in = 0;
	bit calm = 1'b0;
	stim_row_t directed_rows [22];

	window_mean_peak_valley u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.sample         (sample),
		.end_of_vector  (end_of_vector),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.filtered_value (filtered_value),
		.is_peak        (is_peak),
		.is_valley      (is_valley),
		.running_sum    (running_sum),
		.peak_count     (peak_count),
		.valley_count   (valley_count),
		.final_result   (final_result)
	);

	always #2 clk = ~clk;

	// Clear the window, the sum and the counts
	function automatic void clear_window();
		older_smp = 0;
		newer_smp = 0;
		window_fill = 0;
		sum_acc = 0;
		peak_tally = '0;
		valley_tally = '0;
	endfunction

	// Shift one sample into the window and work out the centre result, if any
	function automatic void predict_centre(input logic signed [SW-1:0] c_in, input logic eov,
			output bit yields, output centre_t r);
		longint a;
		longint b;
		longint c;
		longint t;
		longint v;
		longint smax;
		longint smin;
		bit peak;
		bit valley;
		yields = 1'b0;
		r = '0;
		c = longint'(c_in);
		if (window_fill >= 2) begin
			a = older_smp;
			b = newer_smp;
			peak = (b > a) && (b > c);
			valley = (b < a) && (b < c);
			// floor((a+b+c+1)/3) from a truncating divide
			t = a + b + c + 1;
			v = t / 3;
			if (t % 3 < 0)
				v = v - 1;
			if (peak)
				v = v + b;
			smax = (longint'(1) <<< (SUMW - 1)) - 1;
			smin = -smax - 1;
			if (v > 0 && sum_acc > smax - v)
				sum_acc = smax;
			else if (v < 0 && sum_acc < smin - v)
				sum_acc = smin;
			else
				sum_acc = sum_acc + v;
			if (peak && peak_tally != '1)
				peak_tally = peak_tally + 1'b1;
			if (valley && valley_tally != '1)
				valley_tally = valley_tally + 1'b1;
			r.mean_val = (SW+1)'(v);
			r.peak = peak;
			r.valley = valley;
			r.total = SUMW'(sum_acc);
			r.peaks = peak_tally;
			r.valleys = valley_tally;
			r.closing = eov;
			yields = 1'b1;
		end else begin
			window_fill = window_fill + 1;
		end
		older_smp = newer_smp;
		newer_smp = c;
		if (eov)
			clear_window();
	endfunction

	// Offer one word after an optional gap, wait for it to be taken, then predict.
	// Called at a falling edge; returns at a falling edge.
	task automatic put_word(input logic signed [SW-1:0] s, input logic eov, input int gap,
			output bit yields, output centre_t r);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		end_of_vector <= eov;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		words_in++;
		predict_centre(s, eov, yields, r);
		@(negedge clk);
	endtask

	function automatic int pick_gap(int pct);
		if (calm || $urandom_range(0, 99) >= pct)
			return 0;
		return $urandom_range(1, 14);
	endfunction

	function automatic logic signed [SW-1:0] next_sample(sample_style_t style,
			logic signed [SW-1:0] prev);
		int w;
		case (style)
			S_NARROW: return SW'($signed($urandom_range(0, 80)) - 40);
			S_EDGES: begin
				case ($urandom_range(0, 6))
					0: return 16'sh8000;
					1: return 16'sh8001;
					2: return 16'sh7FFF;
					3: return 16'sh7FFE;
					4: return 16'sh0000;
					5: return 16'shFFFF;
					default: return 16'sh0001;
				endcase
			end
			S_WALK: begin
				w = int'(prev) + $signed($urandom_range(0, 2000)) - 1000;
				if (w > 32767)
					w = 32767;
				if (w < -32768)
					w = -32768;
				return SW'(w);
			end
			S_FLAT: begin
				if ($urandom_range(0, 1) == 0)
					return prev;
				return SW'($signed($urandom_range(0, 6)) - 3);
			end
			default: return SW'($urandom());
		endcase
	endfunction

	// Stimulus: directed table, then random vectors
	initial begin
		bit yields;
		centre_t r;
		int len;
		int pct;
		int gap;
		sample_style_t style;
		logic signed [SW-1:0] s;

		directed_rows = '{
			// all-zero vector straight after reset
			'{16'sd0, 1'b0, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{16'sd0, 1'b0, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{16'sd0, 1'b1, 1'b1, 1'b1, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			// full-scale alternation: peak, valley, peak
			'{16'sh8000, 1'b0, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{16'sh7FFF, 1'b0, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{16'sh8000, 1'b0, 1'b1, 1'b1, 17'sd21844, 1'b1, 1'b0, 48'sd21844, 24'd1, 24'd0},
			'{16'sh7FFF, 1'b0, 1'b1, 1'b1, 17'sd10922, 1'b0, 1'b1, 48'sd32766, 24'd1, 24'd1},
			'{16'sh8000, 1'b1, 1'b1, 1'b1, 17'sd21844, 1'b1, 1'b0, 48'sd54610, 24'd2, 24'd1},
			// one-sample and two-sample vectors give nothing
			'{16'sd5, 1'b1, 1'b1, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{16'sd7, 1'b0, 1'b1, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{-16'sd9, 1'b1, 1'b1, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			// plateaus at both rails
			'{16'sh7FFF, 1'b0, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{16'sh7FFF, 1'b0, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{16'sh7FFF, 1'b0, 1'b1, 1'b1, 17'sd32767, 1'b0, 1'b0, 48'sd32767, 24'd0, 24'd0},
			'{16'sh8000, 1'b0, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{16'sh8000, 1'b0, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{16'sh8000, 1'b1, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			// small alternation around zero for rounding of negative thirds
			'{16'sd1, 1'b0, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{-16'sd1, 1'b0, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{16'sd2, 1'b0, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{-16'sd2, 1'b0, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0},
			'{16'sd3, 1'b1, 1'b0, 1'b0, 17'sd0, 1'b0, 1'b0, 48'sd0, 24'd0, 24'd0}
		};

		clear_window();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// walk the directed table
		foreach (directed_rows[i]) begin
			put_word(directed_rows[i].smp, directed_rows[i].eov, pick_gap(20), yields, r);
			if (directed_rows[i].pinned) begin
				if (directed_rows[i].yields) begin
					r.mean_val = directed_rows[i].mean_val;
					r.peak = directed_rows[i].peak;
					r.valley = directed_rows[i].valley;
					r.total = directed_rows[i].total;
					r.peaks = directed_rows[i].peaks;
					r.valleys = directed_rows[i].valleys;
					r.closing = directed_rows[i].eov;
					pending_centres.push_back(r);
				end
			end else if (yields) begin
				pending_centres.push_back(r);
			end
		end

		// random vectors until the item target is met
		s = '0;
		while (words_in < ITEM_TARGET) begin
			case ($urandom_range(0, 19))
				0: len = 1;
				1: len = 2;
				2: len = $urandom_range(40, 120);
				default: len = $urandom_range(3, 16);
			endcase
			style = sample_style_t'($urandom_range(0, 4));
			case ($urandom_range(0, 3))
				0, 1: pct = 0;
				2: pct = 10;
				default: pct = 35;
			endcase
			for (int k = 0; k < len; k++) begin
				if (words_in >= CALM_FROM)
					calm = 1'b1;
				s = next_sample(style, s);
				gap = pick_gap(pct);
				put_word(s, k == len - 1, gap, yields, r);
				if (yields)
					pending_centres.push_back(r);
			end
		end

		// drain and finish
		sample_valid <= 1'b0;
		while (pending_centres.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_centres.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off, none once calm
	initial begin
		bit held = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (calm) begin
				result_ready <= 1'b1;
				@(negedge clk);
			end else if (!held && words_out >= HOLD_OFF_AT) begin
				held = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end else begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
	end

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		centre_t e;
		if (arst_n && result_valid && result_ready) begin
			words_out++;
			if (pending_centres.size() == 0) begin
				$error("result word with nothing expected");
				mismatches++;
			end else begin
				e = pending_centres.pop_front();
				if (filtered_value !== e.mean_val) begin
					$error("filtered_value: expected %0d, got %0d", e.mean_val, filtered_value);
					mismatches++;
				end
				if (is_peak !== e.peak) begin
					$error("is_peak: expected %0d, got %0d", e.peak, is_peak);
					mismatches++;
				end
				if (is_valley !== e.valley) begin
					$error("is_valley: expected %0d, got %0d", e.valley, is_valley);
					mismatches++;
				end
				if (running_sum !== e.total) begin
					$error("running_sum: expected %0d, got %0d", e.total, running_sum);
					mismatches++;
				end
				if (peak_count !== e.peaks) begin
					$error("peak_count: expected %0d, got %0d", e.peaks, peak_count);
					mismatches++;
				end
				if (valley_count !== e.valleys) begin
					$error("valley_count: expected %0d, got %0d", e.valleys, valley_count);
					mismatches++;
				end
				if (final_result !== e.closing) begin
					$error("final_result: expected %0d, got %0d", e.closing, final_result);
					mismatches++;
				end
			end
		end
	end

	// Give up on a hung run
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
